FILE: rtl/core/rbj_pkg.sv
// ----------------------------------------------------------------------------
// rbj_pkg
// Shared widths, constants, the per-beat pipeline record and small helpers
// for the range-bearing observation unit.
// ----------------------------------------------------------------------------
package rbj_pkg;

  // Fixed-point format of all ports.
  localparam int FRACTION_BITS = 16;
  localparam int CORDIC_STEPS  = 31;

  // Internal widths.
  localparam int S_W       = 66;                      // squared distance
  localparam int ROOT_W    = 34;                      // square root bits
  localparam int CX_W      = 44;                      // CORDIC x and y
  localparam int CZ_W      = 36;                      // CORDIC angle, Q30
  localparam int Z_W       = 62 - FRACTION_BITS;      // angle magnitude before reduction
  localparam int MOD_STEPS = 29 - FRACTION_BITS;      // reduction cells
  localparam int NUM_W     = 33 + 2 * FRACTION_BITS;  // dividend width
  localparam int QUO_W     = 2 * FRACTION_BITS + 1;   // quotient bits, one per cell
  localparam int CMP_W     = S_W + QUO_W;             // divider compare width
  localparam int QR_W      = (QUO_W + 1 > 34) ? QUO_W + 1 : 34;
  localparam int LANES     = 4;
  localparam int SH_W      = 6;
  localparam int VEC_MSB   = 40;                      // vectoring input normalized here

  localparam logic signed [CZ_W-1:0] PI_Q30      = CZ_W'(64'sd3373259426);
  localparam logic signed [CZ_W-1:0] HALF_PI_Q30 = CZ_W'(64'sd1686629713);
  localparam logic signed [CZ_W-1:0] TWO_PI_Q30  = CZ_W'(64'sd6746518852);
  localparam logic [63:0]            TWO_PI_WIDE = 64'd6746518852;
  localparam logic signed [CX_W-1:0] GAIN_INV_Q30 = CX_W'(64'sd652032874);
  localparam logic [32:0]            MAG_CAP     = 33'h1_0000_0000;

  // Arctangent of 2^-i in Q2.30, truncated except the last four entries, which are rounded.
  localparam logic [31:0] ATAN_TAB [CORDIC_STEPS] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
    32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
    32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
    32'h00000001
  };

  // Everything one beat carries down the pipeline.
  typedef struct packed {
    logic                          op;
    logic                          degen;
    logic signed [31:0]            rx;
    logic signed [31:0]            ry;
    logic signed [31:0]            a;
    logic signed [32:0]            dx;
    logic signed [32:0]            dy;
    logic                          dx_neg;
    logic                          dy_neg;
    logic                          dy_pos;
    logic [32:0]                   ax;
    logic [32:0]                   ay;
    logic [S_W-1:0]                ax2;
    logic [S_W-1:0]                ay2;
    logic [S_W-1:0]                s;
    logic [S_W-1:0]                rem;
    logic [SH_W-1:0]               vk;
    logic [ROOT_W-1:0]             root;
    logic [ROOT_W-1:0]             rng;
    logic                          zneg;
    logic [Z_W-1:0]                zmag;
    logic signed [CZ_W-1:0]        zr;
    logic                          flip;
    logic signed [CX_W-1:0]        cx;
    logic signed [CX_W-1:0]        cy;
    logic signed [CZ_W-1:0]        cz;
    logic signed [CZ_W-1:0]        bearing;
    logic signed [32:0]            cc;
    logic signed [32:0]            cs;
    logic signed [64:0]            pc;
    logic signed [64:0]            ps;
    logic [LANES-1:0]              lneg;
    logic [LANES-1:0][NUM_W-1:0]   drem;
    logic [LANES-1:0][QUO_W-1:0]   quo;
    logic [LANES-1:0][32:0]        mag;
    logic signed [35:0]            rc;
    logic signed [35:0]            rs;
    logic signed [33:0]            cr;
    logic signed [33:0]            sr;
  } rbj_item_t;

  // Clamp to the 32-bit signed range.
  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    logic signed [31:0] r;
    if (v > 40'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -40'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Position of the highest set bit, zero for a zero word.
  function automatic logic [SH_W-1:0] msb_index(input logic [32:0] v);
    logic [SH_W-1:0] idx;
    idx = '0;
    for (int i = 0; i < 33; i++) begin
      if (v[i]) begin
        idx = SH_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

FILE: rtl/core/rbj_mod_cell.sv
// ----------------------------------------------------------------------------
// rbj_mod_cell
// One step of the angle reduction modulo two pi: subtracts 2*pi*2^J from the
// angle magnitude when it fits.
// ----------------------------------------------------------------------------
module rbj_mod_cell #(
  parameter int J = 0
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  logic              in_vld,
  input  rbj_pkg::rbj_item_t in_item,
  output logic              out_vld,
  output rbj_pkg::rbj_item_t out_item
);
  import rbj_pkg::*;

  localparam logic [Z_W-1:0] STEP_SUB = Z_W'(TWO_PI_WIDE << J);

  rbj_item_t nxt;

  // Conditional subtract of this cell's multiple.
  always_comb begin
    nxt = in_item;
    if (in_item.zmag >= STEP_SUB) begin
      nxt.zmag = in_item.zmag - STEP_SUB;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (adv) begin
      out_vld <= in_vld;
    end
    if (adv) begin
      out_item <= nxt;
    end
  end

endmodule

FILE: rtl/core/rbj_rot_cell.sv
// ----------------------------------------------------------------------------
// rbj_rot_cell
// One square-root digit and, in the first cells, one CORDIC micro-rotation
// (vectoring for observations, rotation for placements).
// ----------------------------------------------------------------------------
module rbj_rot_cell #(
  parameter int IDX = 0
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  logic              in_vld,
  input  rbj_pkg::rbj_item_t in_item,
  output logic              out_vld,
  output rbj_pkg::rbj_item_t out_item
);
  import rbj_pkg::*;

  localparam int BIT = ROOT_W - 1 - IDX;
  localparam int TW  = S_W + 2;

  rbj_item_t              nxt;
  logic [TW-1:0]          trial;
  logic                   fits;
  logic signed [CX_W-1:0] rot_x;
  logic signed [CX_W-1:0] rot_y;
  logic signed [CZ_W-1:0] rot_z;

  // CORDIC micro-rotation; cells past the table only pass the vector along.
  if (IDX < CORDIC_STEPS) begin : g_rot
    localparam logic signed [CZ_W-1:0] STEP_ANG = CZ_W'(ATAN_TAB[IDX]);
    logic signed [CX_W-1:0] xs;
    logic signed [CX_W-1:0] ys;
    logic                   ccw;
    always_comb begin
      xs  = in_item.cx >>> IDX;
      ys  = in_item.cy >>> IDX;
      ccw = in_item.op ? !in_item.cz[CZ_W-1]
                       : (in_item.cy[CX_W-1] || (in_item.cy == '0));
      if (ccw) begin
        rot_x = in_item.cx - ys;
        rot_y = in_item.cy + xs;
        rot_z = in_item.cz - STEP_ANG;
      end else begin
        rot_x = in_item.cx + ys;
        rot_y = in_item.cy - xs;
        rot_z = in_item.cz + STEP_ANG;
      end
    end
  end else begin : g_pass
    assign rot_x = in_item.cx;
    assign rot_y = in_item.cy;
    assign rot_z = in_item.cz;
  end

  // Restoring square-root digit: keep the bit when the square still fits.
  always_comb begin
    nxt   = in_item;
    trial = (TW'(in_item.root) << (BIT + 1)) + (TW'(1) << (2 * BIT));
    fits  = TW'(in_item.rem) >= trial;
    if (fits) begin
      nxt.rem  = in_item.rem - trial[S_W-1:0];
      nxt.root = in_item.root | (ROOT_W'(1) << BIT);
    end
    nxt.cx = rot_x;
    nxt.cy = rot_y;
    nxt.cz = rot_z;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (adv) begin
      out_vld <= in_vld;
    end
    if (adv) begin
      out_item <= nxt;
    end
  end

endmodule

FILE: rtl/core/rbj_div_cell.sv
// ----------------------------------------------------------------------------
// rbj_div_cell
// One quotient bit for each of the four Jacobian divider lanes.
// ----------------------------------------------------------------------------
module rbj_div_cell #(
  parameter int IDX = 0
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  logic              in_vld,
  input  rbj_pkg::rbj_item_t in_item,
  output logic              out_vld,
  output rbj_pkg::rbj_item_t out_item
);
  import rbj_pkg::*;

  localparam int BIT = QUO_W - 1 - IDX;

  rbj_item_t        nxt;
  logic [CMP_W-1:0] dsh [LANES];
  logic [LANES-1:0] ge;

  // Lanes 0 and 1 divide by the range, lanes 2 and 3 by its square.
  always_comb begin
    nxt = in_item;
    for (int l = 0; l < LANES; l++) begin
      dsh[l] = (l < 2) ? (CMP_W'(in_item.rng) << BIT) : (CMP_W'(in_item.s) << BIT);
      ge[l]  = CMP_W'(in_item.drem[l]) >= dsh[l];
      if (ge[l]) begin
        nxt.drem[l] = in_item.drem[l] - dsh[l][NUM_W-1:0];
      end
      nxt.quo[l] = {in_item.quo[l][QUO_W-2:0], ge[l]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (adv) begin
      out_vld <= in_vld;
    end
    if (adv) begin
      out_item <= nxt;
    end
  end

endmodule

FILE: rtl/core/range_bearing_observation_jacobian_top.sv
// ----------------------------------------------------------------------------
// range_bearing_observation_jacobian_top
// Cell chains: the angle reduction, the square-root digits with the CORDIC
// micro-rotations, and the one-bit-per-cell Jacobian dividers.
// Throughput: one beat per cycle; the whole pipeline holds while a result
// waits. Synchronous reset clears the valid bits only; no clearing pass.
// ----------------------------------------------------------------------------
module range_bearing_observation_jacobian_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               obs_valid,
  output logic               obs_ready,
  input  logic               opcode,
  input  logic signed [31:0] robot_x,
  input  logic signed [31:0] robot_y,
  input  logic signed [31:0] first_operand,
  input  logic signed [31:0] second_operand,
  output logic               res_valid,
  input  logic               res_ready,
  output logic signed [31:0] first_result,
  output logic signed [31:0] second_result,
  output logic signed [31:0] lm_jac_00,
  output logic signed [31:0] lm_jac_01,
  output logic signed [31:0] lm_jac_10,
  output logic signed [31:0] lm_jac_11,
  output logic signed [31:0] pose_jac_00,
  output logic signed [31:0] pose_jac_01,
  output logic signed [31:0] pose_jac_10,
  output logic signed [31:0] pose_jac_11,
  output logic               degenerate
);
  import rbj_pkg::*;

  localparam int ANG_SH = 30 - FRACTION_BITS;
  localparam logic signed [CZ_W-1:0] RND_Z = CZ_W'(1) <<< (ANG_SH - 1);
  localparam logic signed [33:0]     RND_C = 34'sd1 <<< (ANG_SH - 1);
  localparam logic signed [65:0]     RND_P = 66'sd1 <<< 29;
  localparam logic signed [31:0]     ONE_FX = 32'sd1 <<< FRACTION_BITS;

  logic adv;
  rbj_item_t s1, s2, s3, s4, s5, s6, s7, s8, f1;
  rbj_item_t n1, n2, n3, n4, n5, n6, n7, n8, nf1;
  logic v1, v2, v3, v4, v5, v6, v7, v8, vf1;

  rbj_item_t mod_item [MOD_STEPS+1];
  logic      mod_vld  [MOD_STEPS+1];
  rbj_item_t rot_item [ROOT_W+1];
  logic      rot_vld  [ROOT_W+1];
  rbj_item_t div_item [QUO_W+1];
  logic      div_vld  [QUO_W+1];

  // The pipeline moves whenever the output register is free or being taken.
  assign adv       = !res_valid || res_ready;
  assign obs_ready = adv;

  // Stage 1: differences and bearing-angle magnitude for placements.
  logic signed [32:0] bw;
  logic [32:0]        babs;
  always_comb begin
    n1      = '0;
    n1.op   = opcode;
    n1.rx   = robot_x;
    n1.ry   = robot_y;
    n1.a    = first_operand;
    n1.dx   = 33'(first_operand) - 33'(robot_x);
    n1.dy   = 33'(second_operand) - 33'(robot_y);
    bw      = 33'(second_operand);
    babs    = bw[32] ? 33'(-bw) : 33'(bw);
    n1.zneg = bw[32];
    n1.zmag = Z_W'(babs) << ANG_SH;
  end

  // Stage 2: magnitudes, signs and the coincident-point flag.
  always_comb begin
    n2        = s1;
    n2.ax     = s1.dx[32] ? 33'(-s1.dx) : 33'(s1.dx);
    n2.ay     = s1.dy[32] ? 33'(-s1.dy) : 33'(s1.dy);
    n2.dx_neg = s1.dx[32];
    n2.dy_neg = s1.dy[32];
    n2.dy_pos = !s1.dy[32] && (s1.dy != '0);
    n2.degen  = !s1.op && (s1.dx == '0) && (s1.dy == '0);
  end

  // Stage 3: squares and the normalizing shift for the vectoring CORDIC.
  logic [32:0] mx;
  always_comb begin
    n3     = s2;
    n3.ax2 = s2.ax * s2.ax;
    n3.ay2 = s2.ay * s2.ay;
    mx     = (s2.ax > s2.ay) ? s2.ax : s2.ay;
    n3.vk  = SH_W'(VEC_MSB) - msb_index(mx);
  end

  // Stage 4: squared range, root seed and vectoring start point.
  logic signed [CX_W-1:0] xv;
  logic signed [CX_W-1:0] yv;
  always_comb begin
    n4      = s3;
    n4.s    = s3.ax2 + s3.ay2;
    n4.rem  = s3.ax2 + s3.ay2;
    n4.root = '0;
    xv      = CX_W'(s3.dx) <<< s3.vk;
    yv      = CX_W'(s3.dy) <<< s3.vk;
    if (s3.dx_neg) begin
      n4.cx = -xv;
      n4.cy = -yv;
      n4.cz = s3.dy_neg ? -PI_Q30 : PI_Q30;
    end else begin
      n4.cx = xv;
      n4.cy = yv;
      n4.cz = '0;
    end
  end

  assign mod_item[0] = s4;
  assign mod_vld[0]  = v4;

  for (genvar j = 0; j < MOD_STEPS; j++) begin : g_mod
    rbj_mod_cell #(.J(MOD_STEPS - 1 - j)) u_mod (
      .clk      (clk),
      .rst      (rst),
      .adv      (adv),
      .in_vld   (mod_vld[j]),
      .in_item  (mod_item[j]),
      .out_vld  (mod_vld[j+1]),
      .out_item (mod_item[j+1])
    );
  end

  // Stage 5: restore the sign of the remainder and wrap into [-pi, pi).
  logic signed [CZ_W-1:0] zs;
  logic signed [CZ_W-1:0] zw;
  always_comb begin
    n5 = mod_item[MOD_STEPS];
    zs = CZ_W'(mod_item[MOD_STEPS].zmag);
    zw = mod_item[MOD_STEPS].zneg ? -zs : zs;
    if (zw >= PI_Q30) begin
      n5.zr = zw - TWO_PI_Q30;
    end else if (zw < -PI_Q30) begin
      n5.zr = zw + TWO_PI_Q30;
    end else begin
      n5.zr = zw;
    end
  end

  // Stage 6: fold into the right half-plane and seed the rotation CORDIC.
  always_comb begin
    n6      = s5;
    n6.flip = 1'b0;
    if (s5.op) begin
      n6.cx = GAIN_INV_Q30;
      n6.cy = '0;
      if (s5.zr > HALF_PI_Q30) begin
        n6.cz   = s5.zr - PI_Q30;
        n6.flip = 1'b1;
      end else if (s5.zr < -HALF_PI_Q30) begin
        n6.cz   = s5.zr + PI_Q30;
        n6.flip = 1'b1;
      end else begin
        n6.cz = s5.zr;
      end
    end
  end

  assign rot_item[0] = s6;
  assign rot_vld[0]  = v6;

  for (genvar i = 0; i < ROOT_W; i++) begin : g_rot
    rbj_rot_cell #(.IDX(i)) u_rot (
      .clk      (clk),
      .rst      (rst),
      .adv      (adv),
      .in_vld   (rot_vld[i]),
      .in_item  (rot_item[i]),
      .out_vld  (rot_vld[i+1]),
      .out_item (rot_item[i+1])
    );
  end

  // Stage 7: rounded range, rounded bearing and the folded cosine and sine.
  logic signed [CZ_W-1:0] bz;
  logic signed [32:0]     xc;
  logic signed [32:0]     yc;
  always_comb begin
    n7         = rot_item[ROOT_W];
    n7.rng     = (rot_item[ROOT_W].rem > S_W'(rot_item[ROOT_W].root))
               ? rot_item[ROOT_W].root + ROOT_W'(1) : rot_item[ROOT_W].root;
    bz         = rot_item[ROOT_W].cz + RND_Z;
    n7.bearing = bz >>> ANG_SH;
    xc         = rot_item[ROOT_W].cx[32:0];
    yc         = rot_item[ROOT_W].cy[32:0];
    n7.cc      = rot_item[ROOT_W].flip ? -xc : xc;
    n7.cs      = rot_item[ROOT_W].flip ? -yc : yc;
  end

  // Stage 8: range times cosine and sine, and the divider dividends.
  always_comb begin
    n8         = s7;
    n8.pc      = s7.a * s7.cc;
    n8.ps      = s7.a * s7.cs;
    n8.drem[0] = NUM_W'(s7.ax) << FRACTION_BITS;
    n8.drem[1] = NUM_W'(s7.ay) << FRACTION_BITS;
    n8.drem[2] = NUM_W'(s7.ay) << (2 * FRACTION_BITS);
    n8.drem[3] = NUM_W'(s7.ax) << (2 * FRACTION_BITS);
    n8.quo     = '0;
    n8.lneg    = {s7.dx_neg, s7.dy_pos, s7.dy_neg, s7.dx_neg};
  end

  assign div_item[0] = s8;
  assign div_vld[0]  = v8;

  for (genvar k = 0; k < QUO_W; k++) begin : g_div
    rbj_div_cell #(.IDX(k)) u_div (
      .clk      (clk),
      .rst      (rst),
      .adv      (adv),
      .in_vld   (div_vld[k]),
      .in_item  (div_item[k]),
      .out_vld  (div_vld[k+1]),
      .out_item (div_item[k+1])
    );
  end

  // Stage 9: round and cap the quotients, and round the products and the cosine and sine.
  logic [CMP_W-1:0]   dvs [LANES];
  logic [QR_W-1:0]    qr  [LANES];
  logic signed [65:0] pct;
  logic signed [65:0] pst;
  logic signed [33:0] cct;
  logic signed [33:0] sst;
  always_comb begin
    nf1 = div_item[QUO_W];
    for (int l = 0; l < LANES; l++) begin
      dvs[l] = (l < 2) ? CMP_W'(div_item[QUO_W].rng) : CMP_W'(div_item[QUO_W].s);
      qr[l]  = QR_W'(div_item[QUO_W].quo[l])
             + QR_W'(CMP_W'({div_item[QUO_W].drem[l], 1'b0}) >= dvs[l]);
      nf1.mag[l] = (qr[l] > QR_W'(MAG_CAP)) ? MAG_CAP : qr[l][32:0];
    end
    pct    = 66'(div_item[QUO_W].pc) + RND_P;
    pst    = 66'(div_item[QUO_W].ps) + RND_P;
    nf1.rc = pct[65:30];
    nf1.rs = pst[65:30];
    cct    = 34'(div_item[QUO_W].cc) + RND_C;
    sst    = 34'(div_item[QUO_W].cs) + RND_C;
    nf1.cr = cct >>> ANG_SH;
    nf1.sr = sst >>> ANG_SH;
  end

  // Output stage: select by opcode, apply signs and saturate.
  logic signed [31:0] o_res [2];
  logic signed [31:0] o_lm  [LANES];
  logic signed [31:0] o_ps  [LANES];
  logic               o_deg;
  logic signed [33:0] sv    [LANES];
  always_comb begin
    o_deg = 1'b0;
    for (int l = 0; l < LANES; l++) begin
      sv[l]   = 34'({1'b0, f1.mag[l]});
      o_lm[l] = '0;
      o_ps[l] = '0;
    end
    o_res[0] = '0;
    o_res[1] = '0;
    if (f1.op) begin
      o_res[0] = sat32(40'(f1.rx) + 40'(f1.rc));
      o_res[1] = sat32(40'(f1.ry) + 40'(f1.rs));
      o_lm[0]  = sat32(40'(f1.cr));
      o_lm[1]  = sat32(-40'(f1.rs));
      o_lm[2]  = sat32(40'(f1.sr));
      o_lm[3]  = sat32(40'(f1.rc));
      o_ps[0]  = ONE_FX;
      o_ps[3]  = ONE_FX;
    end else if (f1.degen) begin
      o_deg = 1'b1;
    end else begin
      o_res[0] = sat32(40'(signed'({1'b0, f1.rng})));
      o_res[1] = sat32(40'(f1.bearing));
      for (int l = 0; l < LANES; l++) begin
        o_lm[l] = sat32(40'(f1.lneg[l] ? -sv[l] : sv[l]));
        o_ps[l] = sat32(40'(f1.lneg[l] ? sv[l] : -sv[l]));
      end
    end
  end

  // Stage registers; only the valid bits are reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      v5        <= 1'b0;
      v6        <= 1'b0;
      v7        <= 1'b0;
      v8        <= 1'b0;
      vf1       <= 1'b0;
      res_valid <= 1'b0;
    end else if (adv) begin
      v1        <= obs_valid;
      v2        <= v1;
      v3        <= v2;
      v4        <= v3;
      v5        <= mod_vld[MOD_STEPS];
      v6        <= v5;
      v7        <= rot_vld[ROOT_W];
      v8        <= v7;
      vf1       <= div_vld[QUO_W];
      res_valid <= vf1;
    end
    if (adv) begin
      s1            <= n1;
      s2            <= n2;
      s3            <= n3;
      s4            <= n4;
      s5            <= n5;
      s6            <= n6;
      s7            <= n7;
      s8            <= n8;
      f1            <= nf1;
      first_result  <= o_res[0];
      second_result <= o_res[1];
      lm_jac_00     <= o_lm[0];
      lm_jac_01     <= o_lm[1];
      lm_jac_10     <= o_lm[2];
      lm_jac_11     <= o_lm[3];
      pose_jac_00   <= o_ps[0];
      pose_jac_01   <= o_ps[1];
      pose_jac_10   <= o_ps[2];
      pose_jac_11   <= o_ps[3];
      degenerate    <= o_deg;
    end
  end

endmodule

FILE: tb/tb_range_bearing_observation_jacobian_top.sv
// ----------------------------------------------------------------------------
// tb_range_bearing_observation_jacobian_top
// Self-checking bench for the range-bearing observation unit. Observation
// beats go in through a valid/ready channel. A fixed-point model in the bench
// computes range, bearing and both Jacobians, or the placed landmark. Each
// result beat is compared field by field with the oldest prediction. Both
// sides insert random gaps, and one stretch of long result backpressure
// fills the pipeline.
// ----------------------------------------------------------------------------
module tb_range_bearing_observation_jacobian_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     FB          = rbj_pkg::FRACTION_BITS;
  localparam logic   OP_FORWARD  = 1'b0;
  localparam logic   OP_INVERSE  = 1'b1;
  localparam longint PI_FX       = 64'sd3373259426;
  localparam longint HALF_PI_FX  = 64'sd1686629713;
  localparam longint TWO_PI_FX   = 64'sd6746518852;
  localparam longint GAIN_FX     = 64'sd652032874;
  localparam int     DRAIN       = 200;
  localparam longint CYCLE_LIMIT = 400000;

  // Arctangent of 2^-i in Q2.30, truncated except the last four entries, which are rounded.
  localparam longint ATAN_FX [31] = '{
    'h3243F6A8, 'h1DAC6705, 'h0FADBAFC, 'h07F56EA6, 'h03FEAB76, 'h01FFD55B,
    'h00FFFAAA, 'h007FFF55, 'h003FFFEA, 'h001FFFFD, 'h000FFFFF, 'h0007FFFF,
    'h0003FFFF, 'h0001FFFF, 'h0000FFFF, 'h00007FFF, 'h00003FFF, 'h00001FFF,
    'h00000FFF, 'h000007FF, 'h000003FF, 'h000001FF, 'h000000FF, 'h0000007F,
    'h0000003F, 'h0000001F, 'h0000000F, 'h00000008, 'h00000004, 'h00000002,
    'h00000001
  };

  typedef struct {
    logic signed [31:0] f [10];
    logic               degen;
  } obs_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               obs_valid = 1'b0;
  logic               obs_ready;
  logic               opcode = OP_FORWARD;
  logic signed [31:0] robot_x = '0;
  logic signed [31:0] robot_y = '0;
  logic signed [31:0] first_operand = '0;
  logic signed [31:0] second_operand = '0;
  logic               res_valid;
  logic               res_ready = 1'b0;
  logic signed [31:0] first_result, second_result;
  logic signed [31:0] lm_jac_00, lm_jac_01, lm_jac_10, lm_jac_11;
  logic signed [31:0] pose_jac_00, pose_jac_01, pose_jac_10, pose_jac_11;
  logic               degenerate;

  obs_result_t pending_results [$];
  int          fail_count = 0;
  longint      cycle_count = 0;
  bit          send_gaps = 1'b1;
  bit          recv_gaps = 1'b1;
  int          recv_hold = 0;
  string       field_names [10] = '{"first_result", "second_result", "lm_jac_00",
    "lm_jac_01", "lm_jac_10", "lm_jac_11", "pose_jac_00", "pose_jac_01",
    "pose_jac_10", "pose_jac_11"};

  always #1 clk = ~clk;

  range_bearing_observation_jacobian_top u_dut (
    .clk(clk), .rst(rst),
    .obs_valid(obs_valid), .obs_ready(obs_ready), .opcode(opcode),
    .robot_x(robot_x), .robot_y(robot_y),
    .first_operand(first_operand), .second_operand(second_operand),
    .res_valid(res_valid), .res_ready(res_ready),
    .first_result(first_result), .second_result(second_result),
    .lm_jac_00(lm_jac_00), .lm_jac_01(lm_jac_01),
    .lm_jac_10(lm_jac_10), .lm_jac_11(lm_jac_11),
    .pose_jac_00(pose_jac_00), .pose_jac_01(pose_jac_01),
    .pose_jac_10(pose_jac_10), .pose_jac_11(pose_jac_11),
    .degenerate(degenerate)
  );

  // ------------------------------------------------------------------------
  // Fixed-point arithmetic of the unit.
  // ------------------------------------------------------------------------
  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic longint round_to(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  // Quotient rounded half up, magnitude capped at 2^32 and then signed.
  function automatic longint ratio_signed(logic [127:0] n, logic [127:0] d, bit neg);
    logic [127:0] q;
    logic [127:0] r;
    longint       v;
    q = n / d;
    r = n % d;
    if ((r << 1) >= d) q = q + 1;
    v = (q > 128'h1_0000_0000) ? 64'sh1_0000_0000 : longint'(q[63:0]);
    return neg ? -v : v;
  endfunction

  // Square root rounded to nearest.
  function automatic logic [127:0] nearest_root(logic [127:0] s);
    logic [127:0] r;
    logic [127:0] t;
    r = '0;
    for (int b = 33; b >= 0; b--) begin
      t = r | (128'd1 << b);
      if (t * t <= s) r = t;
    end
    if (s - r * r > r) r = r + 1;
    return r;
  endfunction

  // Vectoring CORDIC angle of (dx, dy), in output fixed point.
  function automatic longint bearing_angle(longint dx, longint dy);
    longint ax, ay, m, x, y, z, xs, ys;
    int     k;
    ax = dx < 0 ? -dx : dx;
    ay = dy < 0 ? -dy : dy;
    m = ax > ay ? ax : ay;
    k = 0;
    while (m < (64'sd1 <<< 40)) begin
      m = m <<< 1;
      k++;
    end
    x = dx * (64'sd1 <<< k);
    y = dy * (64'sd1 <<< k);
    z = 0;
    if (x < 0) begin
      z = y >= 0 ? PI_FX : -PI_FX;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < 31; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x += ys; y -= xs; z += ATAN_FX[i];
      end else begin
        x -= ys; y += xs; z -= ATAN_FX[i];
      end
    end
    return round_to(z, 30 - FB);
  endfunction

  // Rotation CORDIC cosine and sine in Q2.30, with range reduction.
  function automatic void cos_sin(longint ang, output longint c, output longint s);
    longint z, x, y, xs, ys;
    bit     flip;
    z = ang * (64'sd1 <<< (30 - FB));
    x = GAIN_FX;
    y = 0;
    flip = 1'b0;
    z = z % TWO_PI_FX;
    if (z >= PI_FX) z -= TWO_PI_FX;
    else if (z < -PI_FX) z += TWO_PI_FX;
    if (z > HALF_PI_FX) begin
      z -= PI_FX; flip = 1'b1;
    end else if (z < -HALF_PI_FX) begin
      z += PI_FX; flip = 1'b1;
    end
    for (int i = 0; i < 31; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys; y += xs; z -= ATAN_FX[i];
      end else begin
        x += ys; y -= xs; z += ATAN_FX[i];
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    c = x;
    s = y;
  endfunction

  function automatic obs_result_t observe(logic op, longint rx, longint ry,
                                          longint a, longint b);
    obs_result_t  res;
    longint       v [10];
    longint       dx, dy, ax, ay, c, s, rc, rs;
    logic [127:0] sq, rng;
    foreach (v[j]) v[j] = 0;
    res.degen = 1'b0;
    if (op == OP_FORWARD) begin
      dx = a - rx;
      dy = b - ry;
      if (dx == 0 && dy == 0) begin
        res.degen = 1'b1;
      end else begin
        ax = dx < 0 ? -dx : dx;
        ay = dy < 0 ? -dy : dy;
        sq = 128'(ax) * 128'(ax) + 128'(ay) * 128'(ay);
        rng = nearest_root(sq);
        v[0] = longint'(rng[63:0]);
        v[1] = bearing_angle(dx, dy);
        v[2] = ratio_signed(128'(ax) << FB, rng, dx < 0);
        v[3] = ratio_signed(128'(ay) << FB, rng, dy < 0);
        v[4] = ratio_signed(128'(ay) << (2 * FB), sq, dy > 0);
        v[5] = ratio_signed(128'(ax) << (2 * FB), sq, dx < 0);
        for (int j = 0; j < 4; j++) v[6 + j] = -v[2 + j];
      end
    end else begin
      cos_sin(b, c, s);
      rc = round_to(a * c, 30);
      rs = round_to(a * s, 30);
      v[0] = rx + rc;
      v[1] = ry + rs;
      v[2] = round_to(c, 30 - FB);
      v[3] = -rs;
      v[4] = round_to(s, 30 - FB);
      v[5] = rc;
      v[6] = 64'sd1 <<< FB;
      v[9] = 64'sd1 <<< FB;
    end
    foreach (v[j]) res.f[j] = clamp32(v[j]);
    return res;
  endfunction

  // ------------------------------------------------------------------------
  // Sender: one observation beat, called at a rising edge.
  // ------------------------------------------------------------------------
  task automatic send_obs(logic op, logic signed [31:0] rx, logic signed [31:0] ry,
                          logic signed [31:0] a, logic signed [31:0] b);
    int gap;
    gap = send_gaps ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      obs_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    obs_valid      <= 1'b1;
    opcode         <= op;
    robot_x        <= rx;
    robot_y        <= ry;
    first_operand  <= a;
    second_operand <= b;
    do @(negedge clk); while (!obs_ready);
    @(posedge clk);
    pending_results.insert(pending_results.size(), observe(op, rx, ry, a, b));
  endtask

  // Coordinates: full range, moderate, tiny, or near the limits.
  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(0, 4))
      0, 1: return $urandom;
      2: return $signed($urandom_range(0, 2 ** 24)) - 32'sd8388608;
      3: return $signed($urandom_range(0, 32)) - 32'sd16;
      default: return $urandom_range(0, 1) ? 32'sh7fffffff - $urandom_range(0, 7)
                                           : 32'sh80000000 + $urandom_range(0, 7);
    endcase
  endfunction

  task automatic send_random_forward();
    logic signed [31:0] rx, ry, lx, ly;
    rx = rand_coord();
    ry = rand_coord();
    lx = rand_coord();
    ly = rand_coord();
    // Now and then put the landmark right on or next to the robot.
    case ($urandom_range(0, 9))
      0: begin lx = rx; ly = ry; end
      1: begin lx = rx + $signed($urandom_range(0, 2)) - 1; ly = ry; end
      2: begin lx = rx; ly = ry + $signed($urandom_range(0, 2)) - 1; end
      default: ;
    endcase
    send_obs(OP_FORWARD, rx, ry, lx, ly);
  endtask

  task automatic send_random_inverse();
    send_obs(OP_INVERSE, rand_coord(), rand_coord(), rand_coord(), rand_coord());
  endtask

  // Stop offering beats, then wait until every prediction has been checked.
  task automatic wait_drained();
    obs_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // ------------------------------------------------------------------------
  // Tests.
  // ------------------------------------------------------------------------
  task automatic test_directed();
    logic signed [31:0] maxv, minv, one;
    maxv = 32'sh7fffffff;
    minv = 32'sh80000000;
    one  = 32'sd1 <<< FB;
    // Coincident points, at zero and at the limits.
    send_obs(OP_FORWARD, 0, 0, 0, 0);
    send_obs(OP_FORWARD, maxv, minv, maxv, minv);
    // Largest distances, all four quadrants.
    send_obs(OP_FORWARD, minv, minv, maxv, maxv);
    send_obs(OP_FORWARD, maxv, maxv, minv, minv);
    send_obs(OP_FORWARD, maxv, minv, minv, maxv);
    send_obs(OP_FORWARD, minv, maxv, maxv, minv);
    // Unit offsets: the inverse-square terms saturate.
    send_obs(OP_FORWARD, 0, 0, 1, 0);
    send_obs(OP_FORWARD, 0, 0, 0, -1);
    send_obs(OP_FORWARD, 0, 0, -1, 1);
    // Points on and next to the negative x axis: bearing at plus and minus pi; then a 3-4-5 offset.
    send_obs(OP_FORWARD, 0, 0, -one, 0);
    send_obs(OP_FORWARD, 5, 0, -one, -1);
    send_obs(OP_FORWARD, 0, 0, 3 * one, 4 * one);
    // Inverse placement: zero and negative range, bearing extremes.
    send_obs(OP_INVERSE, 0, 0, 0, 0);
    send_obs(OP_INVERSE, one, -one, -2 * one, one);
    send_obs(OP_INVERSE, 0, 0, maxv, maxv);
    send_obs(OP_INVERSE, 0, 0, minv, minv);
    send_obs(OP_INVERSE, maxv, maxv, maxv, 0);
    send_obs(OP_INVERSE, minv, minv, minv, 0);
    send_obs(OP_INVERSE, 0, 0, one, 32'sd205887);
    send_obs(OP_INVERSE, 0, 0, one, -32'sd205887);
    send_obs(OP_INVERSE, 0, 0, one, 32'sd102944);
    send_obs(OP_INVERSE, 0, 0, one, -32'sd411775);
    wait_drained();
  endtask

  task automatic test_random_mixed(int count);
    repeat (count) begin
      if ($urandom_range(0, 1)) send_random_forward();
      else send_random_inverse();
    end
  endtask

  task automatic test_no_idle(int count);
    send_gaps = 1'b0;
    recv_gaps = 1'b0;
    test_random_mixed(count);
    wait_drained();
    send_gaps = 1'b1;
    recv_gaps = 1'b1;
  endtask

  // The receiver stalls for a long stretch while beats keep coming.
  task automatic test_backpressure(int count);
    send_gaps = 1'b0;
    recv_hold = 300;
    test_random_mixed(count);
    send_gaps = 1'b1;
    wait_drained();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_mixed(200);
    test_backpressure(150);
    test_no_idle(60);
    test_random_mixed(100);
    wait_drained();
    repeat (DRAIN) @(posedge clk);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("tb_range_bearing_observation_jacobian_top passed");
    end else begin
      $display("tb_range_bearing_observation_jacobian_top failed");
    end
    $finish;
  end

  // Receiver: random ready gaps per beat, plus the long hold when asked.
  initial begin
    int gap;
    @(negedge rst);
    @(posedge clk);
    forever begin
      gap = recv_gaps ? $urandom_range(0, 3) : 0;
      gap += recv_hold;
      recv_hold = 0;
      if (gap > 0) begin
        res_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      res_ready <= 1'b1;
      do @(negedge clk); while (!res_valid);
      @(posedge clk);
    end
  end

  // Result check: a beat is taken at the next edge, so compare now.
  always @(negedge clk) begin
    obs_result_t got, want;
    if (!rst && res_valid && res_ready) begin
      got.f = '{first_result, second_result, lm_jac_00, lm_jac_01, lm_jac_10,
                lm_jac_11, pose_jac_00, pose_jac_01, pose_jac_10, pose_jac_11};
      got.degen = degenerate;
      if (pending_results.size() == 0) begin
        $display("%0t: result beat with nothing expected", $realtime);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        foreach (want.f[j]) begin
          if (got.f[j] !== want.f[j]) begin
            $display("%0t: %s expected %0d actual %0d", $realtime, field_names[j],
                     want.f[j], got.f[j]);
            fail_count++;
          end
        end
        if (got.degen !== want.degen) begin
          $display("%0t: degenerate expected %0b actual %0b", $realtime,
                   want.degen, got.degen);
          fail_count++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_range_bearing_observation_jacobian_top failed");
      $finish;
    end
  end

endmodule
